// ----- rtl/core/ust_pkg.sv -----
// Shared types and constants for the unordered set table.
package ust_pkg;

  // Command codes carried in the input word.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Width of the reported element count.
  localparam int unsigned ENTRY_COUNT_W = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic                     was_member;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     refused;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input word and restart the scan
    logic scan_read;   // read the entry at the scan index
    logic scan_step;   // compare the read entry and advance the index
    logic decide;      // apply insert or delete to the count and store
    logic shift_read;  // read the entry above the current index
    logic shift_write; // move the read entry down and advance the index
    logic out_load;    // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // table holds no entries
    logic hit;         // entry read matches the key
    logic last_scan;   // scan index sits on the last held entry
    logic is_delete;   // current word is a delete
    logic found;       // key was located during the scan
    logic shift_more;  // another entry remains to be moved down
    logic out_busy;    // result register holds a word that is stalled
  } dp_stat_t;

endpackage

// ----- rtl/core/ust_ctrl.sv -----
// Controller state machine that sequences scan, update and shift passes.
module ust_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ust_pkg::dp_stat_t stat,
  output ust_pkg::dp_cmd_t  cmd
);

  ust_pkg::state_t state;
  ust_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ust_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ust_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.count_zero ? ust_pkg::ST_DECIDE : ust_pkg::ST_SCAN_RD;
        end
      end
      ust_pkg::ST_SCAN_RD: begin
        state_next = ust_pkg::ST_SCAN_CMP;
      end
      ust_pkg::ST_SCAN_CMP: begin
        if (stat.hit || stat.last_scan) begin
          state_next = ust_pkg::ST_DECIDE;
        end else begin
          state_next = ust_pkg::ST_SCAN_RD;
        end
      end
      ust_pkg::ST_DECIDE: begin
        if (stat.is_delete && stat.found && stat.shift_more) begin
          state_next = ust_pkg::ST_SHIFT_RD;
        end else begin
          state_next = ust_pkg::ST_DONE;
        end
      end
      ust_pkg::ST_SHIFT_RD: begin
        state_next = ust_pkg::ST_SHIFT_WR;
      end
      ust_pkg::ST_SHIFT_WR: begin
        state_next = stat.shift_more ? ust_pkg::ST_SHIFT_RD : ust_pkg::ST_DONE;
      end
      ust_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_next = ust_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ust_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ust_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ust_pkg::ST_SCAN_RD: begin
        cmd.scan_read = 1'b1;
      end
      ust_pkg::ST_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
      end
      ust_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ust_pkg::ST_SHIFT_RD: begin
        cmd.shift_read = 1'b1;
      end
      ust_pkg::ST_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
      end
      ust_pkg::ST_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/ust_dp.sv -----
// Datapath: key store memory, count, scan index and result register.
module ust_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ust_pkg::in_word_t  in_word,
  input  ust_pkg::dp_cmd_t   cmd,
  output ust_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output ust_pkg::out_word_t out_word
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata;
  logic [31:0]   key;
  logic [1:0]    command;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic          found;
  logic          refused;

  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic          is_insert;
  logic          is_full_now;
  logic [CW:0]   idx_plus1;

  assign is_insert   = (command == ust_pkg::CMD_INSERT);
  assign is_full_now = (count == CW'(CAPACITY));
  assign idx_plus1   = (CW + 1)'(idx) + (CW + 1)'(1);

  // Status for the controller. An entry above the index is still to be moved
  // down while the index plus one lies below the count: the old count when the
  // delete is decided, the reduced count during the shift pass.
  always_comb begin
    stat.count_zero = (count == '0);
    stat.hit        = (rdata == key);
    stat.last_scan  = (idx_plus1 == (CW + 1)'(count));
    stat.is_delete  = (command == ust_pkg::CMD_DELETE);
    stat.found      = found;
    stat.shift_more = (idx_plus1 < (CW + 1)'(count));
    stat.out_busy   = out_valid && out_stall;
  end

  // Memory port selection: scan and shift reads, append and shift writes.
  always_comb begin
    rd_en   = cmd.scan_read || cmd.shift_read;
    rd_addr = cmd.shift_read ? AW'(idx_plus1) : idx;
    wr_en   = (cmd.decide && is_insert && !found && !is_full_now) || cmd.shift_write;
    wr_addr = cmd.shift_write ? idx : AW'(count);
    wr_data = cmd.shift_write ? rdata : key;
  end

  // Key store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Captured word, scan index and lookup flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= in_word.key;
      command <= in_word.command;
      idx     <= '0;
      found   <= 1'b0;
      refused <= 1'b0;
    end else if (cmd.scan_step) begin
      if (stat.hit) begin
        found <= 1'b1;
      end else if (!stat.last_scan) begin
        idx <= AW'(idx_plus1);
      end
    end else if (cmd.decide) begin
      refused <= is_insert && !found && is_full_now;
    end else if (cmd.shift_write) begin
      idx <= AW'(idx_plus1);
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.decide) begin
      if (is_insert && !found && !is_full_now) begin
        count <= count + CW'(1);
      end else if (stat.is_delete && found) begin
        count <= count - CW'(1);
      end
    end
  end

  // Result register; the next word can start while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.was_member  <= found;
      out_word.entry_count <= ust_pkg::ENTRY_COUNT_W'(count);
      out_word.is_empty    <= (count == '0);
      out_word.is_full     <= is_full_now;
      out_word.refused     <= refused;
    end
  end

endmodule

// ----- rtl/core/unordered_set_table_top.sv -----
// Words are handled one at a time. The scan reads key store entries one by one through
// the single registered read port (a read state, then a compare state), and a delete
// moves the later entries down the same way (a read state, then a write state). The
// next word is taken once the result is loaded, which waits while an earlier result is
// stalled; a new word is taken while the last result waits.
// Reset (rst, synchronous) empties the table; stored keys are not cleared.
module unordered_set_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ust_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ust_pkg::out_word_t out_word
);

  ust_pkg::dp_cmd_t  cmd;
  ust_pkg::dp_stat_t stat;

  // Sequencer.
  ust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table storage and result formation.
  ust_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ----- tb/ust_set_checker.sv -----
// Checker for the unordered set table: tracks the key table and compares every result word.
`timescale 1ns / 1ps

module ust_set_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ust_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ust_pkg::out_word_t out_word,
  output int unsigned        fail_count,
  output int unsigned        pending,
  output int unsigned        results_checked,
  output int unsigned        refused_seen,
  output int unsigned        full_seen
);

  // Shadow copy of the packed key table and its element count.
  logic [31:0] table_keys [CAPACITY];
  int unsigned table_count;

  // Results predicted for accepted words, oldest first.
  ust_pkg::out_word_t expected_results [$];

  // Applies one command to the shadow table and returns the result it should give.
  function automatic ust_pkg::out_word_t predict_set_op(ust_pkg::in_word_t w);
    ust_pkg::out_word_t res;
    int unsigned        pos;
    bit                 found;
    bit                 dropped;
    pos     = table_count;
    found   = 1'b0;
    dropped = 1'b0;
    for (int unsigned i = 0; i < table_count; i++) begin
      if (!found && table_keys[i] == w.key) begin
        pos   = i;
        found = 1'b1;
      end
    end
    case (w.command)
      ust_pkg::CMD_INSERT: begin
        if (!found) begin
          if (table_count < CAPACITY) begin
            table_keys[table_count] = w.key;
            table_count++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      ust_pkg::CMD_DELETE: begin
        // Removing an entry closes the gap by moving later keys down one place.
        if (found) begin
          table_count--;
          for (int unsigned j = pos; j < table_count; j++) begin
            table_keys[j] = table_keys[j+1];
          end
        end
      end
      default: begin
        // A query, or the unused code, leaves the table alone.
      end
    endcase
    res.was_member  = found;
    res.entry_count = ust_pkg::ENTRY_COUNT_W'(table_count);
    res.is_empty    = (table_count == 0);
    res.is_full     = (table_count == CAPACITY);
    res.refused     = dropped;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count      = 0;
    results_checked = 0;
    refused_seen    = 0;
    full_seen       = 0;
    table_count     = 0;
  end

  assign pending = expected_results.size();

  // Results are compared before new words are predicted; a word's own result
  // can never leave in the cycle the word is taken.
  always @(posedge clk) begin
    ust_pkg::out_word_t want;
    if (rst) begin
      table_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("was_member", 32'(want.was_member), 32'(out_word.was_member));
          check_field("entry_count", 32'(want.entry_count), 32'(out_word.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_word.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_word.is_full));
          check_field("refused", 32'(want.refused), 32'(out_word.refused));
          results_checked++;
          if (want.refused) refused_seen++;
          if (want.is_full) full_seen++;
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        expected_results.push_back(predict_set_op(in_word));
      end
    end
  end

endmodule

// ----- tb/unordered_set_table_top_tb.sv -----
// Testbench top for the unordered set table: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module unordered_set_table_top_tb;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned RAND_WORDS = 1925;
  localparam int unsigned DRAIN_WAIT = 2 * CAPACITY + 8;
  // Code 3 has no operation of its own; the block treats it as a query.
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ust_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ust_pkg::out_word_t out_word;

  logic        idle_enable = 1'b1;
  int unsigned words_sent  = 0;
  logic [31:0] key_pool [24];

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned refused_seen;
  int unsigned full_seen;

  unordered_set_table_top #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  ust_set_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .refused_seen   (refused_seen),
    .full_seen      (full_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The result side stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= idle_enable && ($urandom_range(99) < 7);
  end

  // Offers one word from a falling edge and returns at the falling edge after it is taken.
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] key);
    while (idle_enable && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_word.command <= cmd;
    in_word.key     <= key;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Run limit in case the block hangs.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [1:0]  cmd;
    logic [31:0] key;
    int unsigned pick;
    int unsigned ins_pct;
    int unsigned del_pct;

    // Key pool: random keys, near misses of the first one, and both extremes.
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
    for (int i = 8; i < 16; i++) key_pool[i] = key_pool[0] ^ (32'h1 << $urandom_range(31));
    key_pool[16] = 32'h0000_0000;
    key_pool[17] = 32'hFFFF_FFFF;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extreme keys, duplicates and the unused code.
    send_word(ust_pkg::CMD_QUERY, 32'h0000_0000);
    send_word(ust_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    send_word(ust_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(ust_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(ust_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(ust_pkg::CMD_QUERY, 32'h0000_0000);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF);
    // Fill the table with walking-one keys.
    for (int i = 0; i < CAPACITY - 2; i++) send_word(ust_pkg::CMD_INSERT, 32'h8000_0000 >> i);
    // A new key into the full table is refused; a present one is a no-op.
    send_word(ust_pkg::CMD_INSERT, 32'h5A5A_5A5A);
    send_word(ust_pkg::CMD_INSERT, 32'h8000_0000);
    // Deletes from the middle, the first place and the last place.
    send_word(ust_pkg::CMD_DELETE, 32'h8000_0000 >> 6);
    send_word(ust_pkg::CMD_DELETE, 32'h0000_0000);
    send_word(ust_pkg::CMD_DELETE, 32'h8000_0000 >> (CAPACITY - 3));

    // Random: phases that fill, drain and mix, mostly on pooled keys.
    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      idle_enable = !(n >= 700 && n < 1100);
      case ((n / 160) % 3)
        0: begin
          ins_pct = 65;
          del_pct = 20;
        end
        1: begin
          ins_pct = 20;
          del_pct = 65;
        end
        default: begin
          ins_pct = 40;
          del_pct = 40;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < ins_pct) cmd = ust_pkg::CMD_INSERT;
      else if (pick < ins_pct + del_pct) cmd = ust_pkg::CMD_DELETE;
      else if (pick < 97) cmd = ust_pkg::CMD_QUERY;
      else cmd = CMD_UNUSED;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(23)];
      else key = $urandom();
      send_word(cmd, key);
    end
    in_valid    <= 1'b0;
    idle_enable = 1'b1;

    // Let every expected result arrive, then watch a while for strays.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d words with inserts, deletes and queries over fill and drain phases.",
             words_sent);
    $display("Checked %0d results: %0d refused inserts, %0d with the table full.",
             results_checked, refused_seen, full_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ust_pkg.sv
rtl/core/ust_ctrl.sv
rtl/core/ust_dp.sv
rtl/core/unordered_set_table_top.sv
tb/ust_set_checker.sv
tb/unordered_set_table_top_tb.sv
